// File: design/clock_page_replacement_defines.svh
// Assertion macros shared by the checker.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock_page_replacement: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock_page_replacement: next-cycle check failed");

`endif

// File: design/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int PROCESSES    = 16;
    localparam int MAX_FRAMES   = 64;
    localparam int FRAMES_RESET = 512 / 10;

    localparam int PID_W     = 4;
    localparam int DATA_W    = 32;
    localparam int FIU_W     = 7;
    localparam int SHIFT_W   = 5;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam int PROC_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W  = PROC_W + FRAME_W;
    localparam int SLOTS   = PROCESSES * (2 ** FRAME_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAMES_IN_USE = 1'b0,
        REG_PAGE_SHIFT    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic search;
        logic fill;
        logic sweep;
        logic evict;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic hit;
        logic search_empty;
        logic room;
        logic victim;
    } stat_t;

endpackage

// File: design/cpr_ctrl.sv
`timescale 1ns / 1ps

module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_FILL   = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_EVICT  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = stat.in_range ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.search_empty)
                begin
                    state_next = stat.room ? S_FILL : S_SWEEP;
                end
            end
            S_FILL:   state_next = S_FINISH;
            S_SWEEP:
            begin
                if (stat.victim)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:  state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.search = (state_reg == S_SEARCH);
    assign cmd.fill   = (state_reg == S_FILL);
    assign cmd.sweep  = (state_reg == S_SWEEP);
    assign cmd.evict  = (state_reg == S_EVICT);
    assign cmd.finish = (state_reg == S_FINISH);

endmodule

// File: design/cpr_datapath.sv
`timescale 1ns / 1ps

module cpr_datapath
    import cpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [PID_W-1:0]     process_id,
    input  logic [DATA_W-1:0]    address,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 done,
    output logic                 fault,
    output logic                 evicted_valid,
    output logic [DATA_W-1:0]    evicted_page,
    output logic [DATA_W-1:0]    fault_total
);

    logic [FIU_W-1:0]   frames_in_use_reg;
    logic [SHIFT_W-1:0] page_shift_reg;

    logic [CNT_W-1:0]   used_reg [PROCESSES];
    logic [FRAME_W-1:0] hand_arr_reg [PROCESSES];

    logic [DATA_W-1:0]     page_mem [SLOTS];
    logic [MAX_FRAMES-1:0] ref_mem [PROCESSES];

    logic [PROC_W-1:0]     proc_reg;
    logic                  ok_reg;
    logic [DATA_W-1:0]     page_reg;
    logic [CNT_W-1:0]      lim_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [FRAME_W-1:0]    hand_reg;
    logic [FRAME_W-1:0]    victim_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic                  pend_reg;
    logic [FRAME_W-1:0]    cmp_idx_reg;
    logic [DATA_W-1:0]     page_rd_reg;
    logic [MAX_FRAMES-1:0] ref_row_reg;
    logic                  fault_reg;
    logic                  ev_valid_reg;
    logic [DATA_W-1:0]     ev_page_reg;
    logic [DATA_W-1:0]     counter_reg;
    logic                  done_reg;

    logic [PROC_W-1:0]  proc_in;
    logic               in_range;
    logic [CNT_W-1:0]   lim_calc;
    logic [CNT_W-1:0]   used_sel;
    logic [CNT_W-1:0]   n_calc;
    logic [FRAME_W-1:0] hand_sel;
    logic [FRAME_W-1:0] hand_calc;
    logic               match;
    logic               issue;
    logic [CNT_W-1:0]   hand_inc;
    logic [FRAME_W-1:0] hand_adv;
    logic               victim_now;
    logic               page_rd_en;
    logic [ADDR_W-1:0]  page_rd_addr;
    logic               page_wr_en;
    logic [ADDR_W-1:0]  page_wr_addr;

    assign proc_in  = PROC_W'(process_id);
    assign in_range = (32'(process_id) < 32'(PROCESSES));

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            lim_calc = CNT_W'(1);
        end
        else if (32'(frames_in_use_reg) > 32'(MAX_FRAMES))
        begin
            lim_calc = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            lim_calc = CNT_W'(frames_in_use_reg);
        end
    end

    assign used_sel  = used_reg[proc_in];
    assign n_calc    = (used_sel > lim_calc) ? lim_calc : used_sel;
    assign hand_sel  = hand_arr_reg[proc_in];
    assign hand_calc = (CNT_W'(hand_sel) >= lim_calc) ? '0 : hand_sel;

    assign match      = pend_reg && (page_rd_reg == page_reg);
    assign issue      = cmd.search && (idx_reg < n_reg) && !match;
    assign hand_inc   = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_adv   = (hand_inc >= lim_reg) ? '0 : FRAME_W'(hand_inc);
    assign victim_now = !ref_row_reg[hand_reg];

    assign page_rd_en   = issue || (cmd.sweep && victim_now);
    assign page_rd_addr = cmd.sweep ? {proc_reg, hand_reg} : {proc_reg, FRAME_W'(idx_reg)};
    assign page_wr_en   = cmd.fill || cmd.evict;
    assign page_wr_addr = cmd.fill ? {proc_reg, FRAME_W'(n_reg)} : {proc_reg, victim_reg};

    assign stat.in_range     = in_range;
    assign stat.hit          = match;
    assign stat.search_empty = !pend_reg && (idx_reg >= n_reg);
    assign stat.room         = (n_reg < lim_reg);
    assign stat.victim       = victim_now;

    always_ff @(posedge clk)
    begin
        if (page_wr_en)
        begin
            page_mem[page_wr_addr] <= page_reg;
        end
        if (page_rd_en)
        begin
            page_rd_reg <= page_mem[page_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ref_row_reg <= ref_mem[proc_in];
        end
        else if (cmd.search && match)
        begin
            ref_row_reg[cmp_idx_reg] <= 1'b1;
        end
        else if (cmd.fill)
        begin
            ref_row_reg[FRAME_W'(n_reg)] <= 1'b1;
        end
        else if (cmd.sweep)
        begin
            ref_row_reg[hand_reg] <= victim_now;
        end
        if (cmd.finish && ok_reg)
        begin
            ref_mem[proc_reg] <= ref_row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            proc_reg     <= proc_in;
            page_reg     <= address >> page_shift_reg;
            lim_reg      <= lim_calc;
            n_reg        <= n_calc;
            hand_reg     <= hand_calc;
            fault_reg    <= 1'b0;
            ev_valid_reg <= 1'b0;
            ev_page_reg  <= '0;
        end
        if (issue)
        begin
            cmp_idx_reg <= FRAME_W'(idx_reg);
        end
        if (cmd.fill)
        begin
            fault_reg <= 1'b1;
        end
        if (cmd.sweep)
        begin
            fault_reg <= 1'b1;
            hand_reg  <= hand_adv;
            if (victim_now)
            begin
                victim_reg <= hand_reg;
            end
        end
        if (cmd.evict)
        begin
            ev_valid_reg <= 1'b1;
            ev_page_reg  <= page_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FIU_W'(FRAMES_RESET);
            page_shift_reg    <= '0;
            ok_reg            <= 1'b0;
            idx_reg           <= '0;
            pend_reg          <= 1'b0;
            counter_reg       <= '0;
            done_reg          <= 1'b0;
            for (int i = 0; i < PROCESSES; i++)
            begin
                used_reg[i]     <= '0;
                hand_arr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAMES_IN_USE: frames_in_use_reg <= cfg_data[FIU_W-1:0];
                    REG_PAGE_SHIFT:    page_shift_reg    <= cfg_data[SHIFT_W-1:0];
                    default:           ;
                endcase
            end
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                ok_reg   <= in_range;
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.search)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (cmd.fill)
            begin
                used_reg[proc_reg] <= n_reg + CNT_W'(1);
            end
            if (cmd.evict)
            begin
                hand_arr_reg[proc_reg] <= hand_reg;
            end
            if (cmd.finish && fault_reg && (counter_reg != '1))
            begin
                counter_reg <= counter_reg + DATA_W'(1);
            end
        end
    end

    assign done          = done_reg;
    assign fault         = fault_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = counter_reg;

endmodule

// File: design/clock_page_replacement.sv
`timescale 1ns / 1ps

// Clock (second-chance) page replacement for up to 16 processes with up to 64 frames each.
// A reference is accepted when start is high and busy is low. Its result appears once on the
// result ports with done high for exactly one cycle and must be taken in that cycle, since
// the block cannot be stalled. A hit ends the search at the first resident frame that matches.
// A miss first compares all n resident frames (at most 64).
// It then writes the page into a free frame when one remains, also when the process holds no frame yet.
// Otherwise the hand passes over frames with a set reference bit, clearing each, until it
// reaches the victim (at most 64 passed over), whose page is replaced and reported as evicted.
// The page memory's single read port compares one frame per cycle, and the hand
// tests one reference bit per cycle. Busy is high
// from the cycle after acceptance until done rises, so one reference is in flight at a time.
// A new reference may be accepted in the cycle in which done is high. No clearing pass
// follows reset: a per-process fill count keeps unwritten frames out of use.
module clock_page_replacement
    import cpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [PID_W-1:0]     process_id,
    input  logic [DATA_W-1:0]    address,
    output logic                 done,
    output logic                 fault,
    output logic                 evicted_valid,
    output logic [DATA_W-1:0]    evicted_page,
    output logic [DATA_W-1:0]    fault_total
);

    cmd_t  cmd;
    stat_t stat;

    cpr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cpr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .process_id    (process_id),
        .address       (address),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .fault         (fault),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

endmodule

// File: design/cpr_checker.sv
`timescale 1ns / 1ps
`include "clock_page_replacement_defines.svh"

module cpr_checker
    import cpr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 fault,
    input logic                 evicted_valid,
    input logic [DATA_W-1:0]    evicted_page,
    input logic [DATA_W-1:0]    fault_total
);

    // A new transaction is taken only when the previous result is out.
    `CPR_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `CPR_ASSERT_SAME(a_done_idle, done, !busy)
    // An eviction only happens on a fault, and the page reads zero without one.
    `CPR_ASSERT_SAME(a_evict_fault, done && evicted_valid, fault)
    `CPR_ASSERT_SAME(a_no_evict_zero, done && !evicted_valid, evicted_page == '0)
    // A hit leaves the running fault count untouched.
    `CPR_ASSERT_SAME(a_hit_count, done && !fault, $stable(fault_total))

endmodule

bind clock_page_replacement cpr_checker u_checker (.*);
